/* rtl/core/pamb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamb_pkg
// Shared types, register indexes and arithmetic helpers of the premultiplied
// alpha blend and RGB565 compose pipeline.
// ----------------------------------------------------------------------------
package pamb_pkg;

   // Request kinds
   localparam logic REQ_BLEND   = 1'b0;
   localparam logic REQ_COMPOSE = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 24;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRAW_COLOR       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPACITY          = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BACKGROUND_COLOR = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHROMA_COLOR     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPAQUE_MODE      = 3'd4;

   // Register reset values
   localparam logic [23:0] DRAW_COLOR_RESET       = 24'hFFFFFF;
   localparam logic [7:0]  OPACITY_RESET          = 8'd255;
   localparam logic [23:0] BACKGROUND_COLOR_RESET = 24'h000000;
   localparam logic [23:0] CHROMA_COLOR_RESET     = 24'h00FF00;
   localparam logic        OPAQUE_MODE_RESET      = 1'b0;

   // Arithmetic constants
   localparam logic [7:0]  FULL_SCALE   = 8'd255;
   localparam logic [15:0] ROUND_BIAS   = 16'd127;
   // ceil(2^23 / 255): exact floor(x / 255) for x below 66052
   localparam logic [15:0] DIV255_RECIP = 16'h8081;
   localparam logic [15:0] KEY_FLIP     = 16'h0020;

   typedef struct packed {
      logic       req_type;
      logic [7:0] coverage;
      logic [7:0] dest_red;
      logic [7:0] dest_green;
      logic [7:0] dest_blue;
      logic [7:0] dest_alpha;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_red;
      logic [7:0]  out_green;
      logic [7:0]  out_blue;
      logic [7:0]  out_alpha;
      logic [15:0] pixel_565;
   } rsp_payload_type;

   typedef struct packed {
      logic [23:0] draw_color;
      logic [7:0]  opacity;
      logic [23:0] background_color;
      logic [23:0] chroma_color;
      logic        opaque_mode;
   } cfg_type;

   // Front half to back half: scaled alpha and background terms
   typedef struct packed {
      logic            valid;
      req_payload_type payload;
      logic [7:0]      alpha;
      logic [7:0]      bg_term_red;
      logic [7:0]      bg_term_green;
      logic [7:0]      bg_term_blue;
   } front_out_type;

   // Rounded (x + 127) / 255 via reciprocal multiply
   function automatic logic [7:0] div255_round(input logic [15:0] x);
      logic [16:0] biased;
      logic [32:0] prod;
      biased = {1'b0, x} + {1'b0, ROUND_BIAS};
      prod   = 33'(biased) * 33'(DIV255_RECIP);
      return prod[30:23];
   endfunction

   // Pack 8-bit channels to RGB565
   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

/* rtl/core/pamb_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamb_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pamb_csr
   import pamb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   // Decode the write; ignore unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DRAW_COLOR:       cfg_in.draw_color       = csr_wdata[23:0];
            CSR_OPACITY:          cfg_in.opacity          = csr_wdata[7:0];
            CSR_BACKGROUND_COLOR: cfg_in.background_color = csr_wdata[23:0];
            CSR_CHROMA_COLOR:     cfg_in.chroma_color     = csr_wdata[23:0];
            CSR_OPAQUE_MODE:      cfg_in.opaque_mode      = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.draw_color       <= DRAW_COLOR_RESET;
         cfg_ff.opacity          <= OPACITY_RESET;
         cfg_ff.background_color <= BACKGROUND_COLOR_RESET;
         cfg_ff.chroma_color     <= CHROMA_COLOR_RESET;
         cfg_ff.opaque_mode      <= OPAQUE_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/pamb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamb_front
// Stages 1 and 2: coverage times opacity and background times inverse
// alpha, then rounded division by 255 of those products.
// ----------------------------------------------------------------------------
module pamb_front
   import pamb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  req_payload_type in_payload,
   input  cfg_type         cfg,
   output front_out_type   front_out
);

   // Stage 1 registers
   logic            s1_valid_ff;
   req_payload_type s1_payload_ff;
   logic [15:0]     s1_alpha_prod_ff, s1_alpha_prod_in;
   logic [15:0]     s1_bg_red_ff, s1_bg_red_in;
   logic [15:0]     s1_bg_green_ff, s1_bg_green_in;
   logic [15:0]     s1_bg_blue_ff, s1_bg_blue_in;
   logic [7:0]      inv_dest_alpha;

   // Stage 2 registers
   front_out_type   s2_ff, s2_in;

   // Form the products
   always_comb begin
      inv_dest_alpha   = FULL_SCALE - in_payload.dest_alpha;
      s1_alpha_prod_in = 16'(in_payload.coverage) * 16'(cfg.opacity);
      s1_bg_red_in     = 16'(cfg.background_color[23:16]) * 16'(inv_dest_alpha);
      s1_bg_green_in   = 16'(cfg.background_color[15:8]) * 16'(inv_dest_alpha);
      s1_bg_blue_in    = 16'(cfg.background_color[7:0]) * 16'(inv_dest_alpha);
   end

   // Divide by 255 with rounding
   always_comb begin
      s2_in.valid         = s1_valid_ff;
      s2_in.payload       = s1_payload_ff;
      s2_in.alpha         = div255_round(s1_alpha_prod_ff);
      s2_in.bg_term_red   = div255_round(s1_bg_red_ff);
      s2_in.bg_term_green = div255_round(s1_bg_green_ff);
      s2_in.bg_term_blue  = div255_round(s1_bg_blue_ff);
   end

   // Advance valid bits; hold everything on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_ff.valid <= s2_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_payload_ff       <= in_payload;
         s1_alpha_prod_ff    <= s1_alpha_prod_in;
         s1_bg_red_ff        <= s1_bg_red_in;
         s1_bg_green_ff      <= s1_bg_green_in;
         s1_bg_blue_ff       <= s1_bg_blue_in;
         s2_ff.payload       <= s2_in.payload;
         s2_ff.alpha         <= s2_in.alpha;
         s2_ff.bg_term_red   <= s2_in.bg_term_red;
         s2_ff.bg_term_green <= s2_in.bg_term_green;
         s2_ff.bg_term_blue  <= s2_in.bg_term_blue;
      end
   end

   assign front_out = s2_ff;

endmodule

/* rtl/core/pamb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamb_back
// Stage 3: blend sums of products and the finished compose pixel.
// Stage 4: rounded division of the blend sums, or the compose pixel, into the output register.
// ----------------------------------------------------------------------------
module pamb_back
   import pamb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  front_out_type   front_out,
   input  cfg_type         cfg,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   // Stage 3 registers
   logic            s3_valid_ff;
   req_payload_type s3_payload_ff;
   logic [7:0]      s3_alpha_ff;
   logic [15:0]     s3_sum_red_ff, s3_sum_red_in;
   logic [15:0]     s3_sum_green_ff, s3_sum_green_in;
   logic [15:0]     s3_sum_blue_ff, s3_sum_blue_in;
   logic [15:0]     s3_alpha_prod_ff, s3_alpha_prod_in;
   logic [15:0]     s3_pixel_ff, s3_pixel_in;

   // Output registers
   logic            s4_valid_ff;
   rsp_payload_type s4_payload_ff, s4_payload_in;

   logic [7:0]      inv_alpha;
   logic [7:0]      comp_red, comp_green, comp_blue;
   logic [15:0]     key, packed_pixel;

   // Blend sums and compose with chroma keying
   always_comb begin
      inv_alpha        = FULL_SCALE - front_out.alpha;
      s3_sum_red_in    = 16'(cfg.draw_color[23:16]) * 16'(front_out.alpha)
                       + 16'(front_out.payload.dest_red) * 16'(inv_alpha);
      s3_sum_green_in  = 16'(cfg.draw_color[15:8]) * 16'(front_out.alpha)
                       + 16'(front_out.payload.dest_green) * 16'(inv_alpha);
      s3_sum_blue_in   = 16'(cfg.draw_color[7:0]) * 16'(front_out.alpha)
                       + 16'(front_out.payload.dest_blue) * 16'(inv_alpha);
      s3_alpha_prod_in = 16'(front_out.payload.dest_alpha) * 16'(inv_alpha);

      comp_red     = front_out.payload.dest_red + front_out.bg_term_red;
      comp_green   = front_out.payload.dest_green + front_out.bg_term_green;
      comp_blue    = front_out.payload.dest_blue + front_out.bg_term_blue;
      packed_pixel = pack565(comp_red, comp_green, comp_blue);
      key          = pack565(cfg.chroma_color[23:16], cfg.chroma_color[15:8],
                             cfg.chroma_color[7:0]);
      priority if (front_out.payload.dest_alpha == 8'd0 && !cfg.opaque_mode) begin
         s3_pixel_in = key;
      end else if (!cfg.opaque_mode && packed_pixel == key) begin
         s3_pixel_in = packed_pixel ^ KEY_FLIP;
      end else begin
         s3_pixel_in = packed_pixel;
      end
   end

   // Finish the blend or pass the pixel through
   always_comb begin
      s4_payload_in.out_red   = s3_payload_ff.dest_red;
      s4_payload_in.out_green = s3_payload_ff.dest_green;
      s4_payload_in.out_blue  = s3_payload_ff.dest_blue;
      s4_payload_in.out_alpha = s3_payload_ff.dest_alpha;
      s4_payload_in.pixel_565 = 16'd0;
      unique case (s3_payload_ff.req_type)
         REQ_BLEND: begin
            if (s3_alpha_ff != 8'd0) begin
               s4_payload_in.out_red   = div255_round(s3_sum_red_ff);
               s4_payload_in.out_green = div255_round(s3_sum_green_ff);
               s4_payload_in.out_blue  = div255_round(s3_sum_blue_ff);
               s4_payload_in.out_alpha = s3_alpha_ff + div255_round(s3_alpha_prod_ff);
            end
         end
         REQ_COMPOSE: begin
            s4_payload_in.pixel_565 = s3_pixel_ff;
         end
         default: begin
            s4_payload_in.pixel_565 = 16'd0;
         end
      endcase
   end

   // Advance valid bits; hold everything on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= front_out.valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_payload_ff    <= front_out.payload;
         s3_alpha_ff      <= front_out.alpha;
         s3_sum_red_ff    <= s3_sum_red_in;
         s3_sum_green_ff  <= s3_sum_green_in;
         s3_sum_blue_ff   <= s3_sum_blue_in;
         s3_alpha_prod_ff <= s3_alpha_prod_in;
         s3_pixel_ff      <= s3_pixel_in;
         s4_payload_ff    <= s4_payload_in;
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_payload = s4_payload_ff;

endmodule

/* rtl/core/premul_alpha_blend_rgb565_compose.sv */
`timescale 1ns / 1ps
// A request passes the stage 1, 2 and 3 registers and then the response register.
// Throughput: one transaction per cycle; the four-stage pipeline moves as one
// and holds all stages while the response register is valid and stalled.
// Reset: synchronous, clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// premul_alpha_blend_rgb565_compose
// Blends the draw color over premultiplied pixels and composes pixels to
// RGB565 over the background with chroma keying.
// ----------------------------------------------------------------------------
module premul_alpha_blend_rgb565_compose
   import pamb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type       cfg;
   front_out_type front_out;
   logic          advance;

   // Move the pipeline unless the response is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   pamb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   pamb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .in_payload (req_payload),
      .cfg        (cfg),
      .front_out  (front_out)
   );

   pamb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .front_out   (front_out),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

/* rtl/core/pamb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pamb_checker
// Port-level checks of the compose pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pamb_checker
   import pamb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   // Stall requests only behind a held response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // Deliver an accepted transaction through the pipeline while the response is not stalled
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         |=> rsp_valid)
      else $error("response missing after pipeline latency");

   // Come out of reset empty
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind premul_alpha_blend_rgb565_compose pamb_checker u_pamb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
